>>> src/jsam_pkg.sv
// Shared constants and types for the joystick slew arcade mixer.
package jsam_pkg;

  localparam int STICK_W = 8;
  localparam int STEP_W  = 7;
  localparam int GAIN_W  = 8;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam int STICK_MAX_DEF = 127;
  localparam int FRAC_BITS_DEF = 8;

  localparam logic [STEP_W-1:0] RISE_STEP_RST = 7'd50;
  localparam logic [STEP_W-1:0] FALL_STEP_RST = 7'd50;
  localparam logic [GAIN_W-1:0] TURN_GAIN_RST = 8'd179;
  localparam logic              LEFT_PLUS_RST = 1'b1;

  typedef enum logic [1:0] {
    REG_RISE_STEP,
    REG_FALL_STEP,
    REG_TURN_GAIN,
    REG_LEFT_PLUS
  } reg_idx_t;

endpackage

>>> src/joystick_slew_arcade_mixer.sv
// Arcade drive mixer with square-law shaping and slew-rate limited levels.
//
// Input channel (in_valid/in_ready) carries one request per control tick:
// forward_stick, turn_stick_a, turn_stick_b. The output channel
// (out_valid/out_ready) returns one request per input: left_drive and
// right_drive. An accepted input lands in an input register; from there the
// goal table lookup, slew update, turn gain multiply, mix and saturation
// run combinationally in one pass and load the result register, which raises
// out_valid; throughput is one request per cycle while out_ready stays high.
// When the receiver stalls, the result register holds and the input register
// still takes one more request; then in_ready drops until out_ready returns.
// Reset (rst, synchronous) empties both registers, zeroes the two levels and
// loads the register defaults: rise_step 50, fall_step 50, turn_gain 179,
// left_plus 1.
// Configuration goes through the APB-style port, registers at byte addresses
// 0, 4, 8, 12; write only while no request is in flight.
module joystick_slew_arcade_mixer import jsam_pkg::*; #(
  parameter int STICK_MAX = STICK_MAX_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [STICK_W-1:0] forward_stick,
  input  logic signed [STICK_W-1:0] turn_stick_a,
  input  logic signed [STICK_W-1:0] turn_stick_b,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [STICK_W-1:0] left_drive,
  output logic signed [STICK_W-1:0] right_drive
);

  localparam int MAG_MAX  = (STICK_MAX < 128) ? STICK_MAX : 128;
  localparam int MAG_W    = $clog2(MAG_MAX + 1);
  localparam longint GOAL_MAX = ((longint'(MAG_MAX) * MAG_MAX) << FRAC_BITS) / STICK_MAX;
  localparam int LW       = $clog2(GOAL_MAX + 1);
  localparam int SW       = ((LW > STEP_W + FRAC_BITS) ? LW : STEP_W + FRAC_BITS) + 1;
  localparam int PW       = LW + 10;
  localparam int QW       = PW - FRAC_BITS - 8;

  // configuration
  logic [STEP_W-1:0] rise_step;
  logic [STEP_W-1:0] fall_step;
  logic [GAIN_W-1:0] turn_gain;
  logic              left_plus;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_step <= RISE_STEP_RST;
      fall_step <= FALL_STEP_RST;
      turn_gain <= TURN_GAIN_RST;
      left_plus <= LEFT_PLUS_RST;
    end else if (cfg_write) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_RISE_STEP: rise_step <= pwdata[STEP_W-1:0];
        REG_FALL_STEP: fall_step <= pwdata[STEP_W-1:0];
        REG_TURN_GAIN: turn_gain <= pwdata[GAIN_W-1:0];
        REG_LEFT_PLUS: left_plus <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_RISE_STEP: prdata = DATA_W'(rise_step);
      REG_FALL_STEP: prdata = DATA_W'(fall_step);
      REG_TURN_GAIN: prdata = DATA_W'(turn_gain);
      REG_LEFT_PLUS: prdata = DATA_W'(left_plus);
      default:       prdata = '0;
    endcase
  end

  // square-law goal table, m*m/STICK_MAX in Q.FRAC_BITS
  logic [LW-1:0] goal_rom [MAG_MAX+1];

  for (genvar i = 0; i <= MAG_MAX; i++) begin : g_goal
    localparam longint G = ((longint'(i) * i) << FRAC_BITS) / STICK_MAX;
    assign goal_rom[i] = LW'(G);
  end

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [STICK_W-1:0] v);
    logic [STICK_W-1:0] a;
    a = v[STICK_W-1] ? STICK_W'(-v) : STICK_W'(v);
    return (a > STICK_W'(MAG_MAX)) ? MAG_W'(MAG_MAX) : MAG_W'(a);
  endfunction

  function automatic logic [LW-1:0] slew(input logic [LW-1:0] lvl,
                                         input logic [LW-1:0] goal,
                                         input logic [SW-1:0] up,
                                         input logic [SW-1:0] down);
    logic [SW-1:0] gap;
    if (goal > lvl) begin
      gap = SW'(goal) - SW'(lvl);
      return (gap <= up) ? goal : LW'(SW'(lvl) + up);
    end else if (goal < lvl) begin
      gap = SW'(lvl) - SW'(goal);
      return (gap <= down) ? goal : LW'(SW'(lvl) - down);
    end
    return lvl;
  endfunction

  // truncate toward zero, saturate, keep low 8 bits
  function automatic logic [STICK_W-1:0] finish(input logic signed [PW-1:0] s);
    logic [PW-1:0]      m;
    logic [QW-1:0]      q;
    logic [STICK_W-1:0] r;
    m = s[PW-1] ? PW'(-s) : PW'(s);
    q = QW'(m >> (FRAC_BITS + 8));
    r = (32'(q) > 32'(STICK_MAX)) ? STICK_W'(STICK_MAX) : STICK_W'(q);
    return s[PW-1] ? STICK_W'(STICK_W'(0) - r) : r;
  endfunction

  // handshake
  logic out_load;
  logic s1_valid;
  logic s1_adv;

  assign out_load = !out_valid || out_ready;
  assign s1_adv   = s1_valid && out_load;
  assign in_ready = !s1_valid || out_load;

  logic signed [STICK_W-1:0] s1_fwd;
  logic signed [STICK_W-1:0] s1_ta;
  logic signed [STICK_W-1:0] s1_tb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_fwd <= forward_stick;
      s1_ta  <= turn_stick_a;
      s1_tb  <= turn_stick_b;
    end
  end

  // single pass
  logic [MAG_W-1:0]          fwd_mag;
  logic [MAG_W-1:0]          ta_mag;
  logic [MAG_W-1:0]          tb_mag;
  logic signed [STICK_W-1:0] turn;
  logic [MAG_W-1:0]          turn_mag;
  logic [SW-1:0]             up;
  logic [SW-1:0]             down;
  logic [LW-1:0]             fwd_level;
  logic [LW-1:0]             turn_level;
  logic [LW-1:0]             fwd_level_next;
  logic [LW-1:0]             turn_level_next;
  logic [LW+7:0]             fwd_q;
  logic [LW+7:0]             turn_q;
  logic signed [PW-1:0]      fwd_part;
  logic signed [PW-1:0]      turn_part;
  logic signed [PW-1:0]      sum_plus;
  logic signed [PW-1:0]      sum_minus;
  logic [STICK_W-1:0]        plus_drive;
  logic [STICK_W-1:0]        minus_drive;

  always_comb begin
    fwd_mag  = mag_of(s1_fwd);
    ta_mag   = mag_of(s1_ta);
    tb_mag   = mag_of(s1_tb);
    turn     = (tb_mag < ta_mag) ? s1_ta : s1_tb;
    turn_mag = (tb_mag < ta_mag) ? ta_mag : tb_mag;
    up       = SW'(rise_step) << FRAC_BITS;
    down     = SW'(fall_step) << FRAC_BITS;

    fwd_level_next  = slew(fwd_level, goal_rom[fwd_mag], up, down);
    turn_level_next = slew(turn_level, goal_rom[turn_mag], up, down);

    fwd_q  = {fwd_level_next, 8'd0};
    turn_q = turn_level_next * turn_gain;

    fwd_part = signed'({2'b00, fwd_q});
    if (s1_fwd == '0) begin
      fwd_part = '0;
    end else if (s1_fwd[STICK_W-1]) begin
      fwd_part = -fwd_part;
    end

    turn_part = signed'({2'b00, turn_q});
    if (turn == '0) begin
      turn_part = '0;
    end else if (turn[STICK_W-1]) begin
      turn_part = -turn_part;
    end

    sum_plus    = fwd_part + turn_part;
    sum_minus   = fwd_part - turn_part;
    plus_drive  = finish(sum_plus);
    minus_drive = finish(sum_minus);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_level  <= '0;
      turn_level <= '0;
    end else if (s1_adv) begin
      fwd_level  <= fwd_level_next;
      turn_level <= turn_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      left_drive  <= left_plus ? plus_drive : minus_drive;
      right_drive <= left_plus ? minus_drive : plus_drive;
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    (64'(fwd_level) <= 64'(GOAL_MAX)) && (64'(turn_level) <= 64'(GOAL_MAX)))
    else $error("level above largest goal");

  a_level_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_adv |=> $stable(fwd_level) && $stable(turn_level))
    else $error("level moved without a request");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_adv_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("request lost between stages");

endmodule
